// ===== design/st_pkg.sv =====
// ----------------------------------------------------------------------------
// st_pkg
// shared types, character codes and classifiers for the source tokenizer
// ----------------------------------------------------------------------------
package st_pkg;

  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RESULTS = 3;

  typedef enum logic [6:0] {
    M_IDLE     = 7'b0000001,
    M_IDENT    = 7'b0000010,
    M_NUMBER   = 7'b0000100,
    M_FRACTION = 7'b0001000,
    M_DASH     = 7'b0010000,
    M_SLASH    = 7'b0100000,
    M_COMMENT  = 7'b1000000
  } scan_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0]       count;
    token_t [2:0]     item;
  } token_group_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_ident_start(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (b == CH_UNDER);
  endfunction

  function automatic logic is_ident_rest(input logic [7:0] b);
    return is_ident_start(b) || is_digit(b);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {CH_TAB, CH_NL, CH_CR, CH_SPACE};
  endfunction

endpackage

// ===== design/st_scan.sv =====
// ----------------------------------------------------------------------------
// st_scan
// scanner state and per-word token decision, up to three tokens per word
// ----------------------------------------------------------------------------
module st_scan #(
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           byte_value,
  input  logic                 final_byte,
  output st_pkg::token_group_t group
);

  localparam int P = POSITION_BITS;

  st_pkg::scan_mode_t mode, mode_next;
  logic [P-1:0] byte_offset, byte_offset_next;
  logic [P-1:0] cur_line, cur_line_next;
  logic [P-1:0] cur_column, cur_column_next;
  logic [P-1:0] tok_start, tok_start_next;
  logic [P-1:0] tok_length, tok_length_next;
  logic [P-1:0] tok_line, tok_line_next;
  logic [P-1:0] tok_column, tok_column_next;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == {P{1'b1}}) ? v : v + 1'b1;
  endfunction

  always_comb begin
    st_pkg::scan_mode_t m1, m2;
    logic               consumed;
    logic               newline;
    logic [P-1:0]       len1;
    logic [P-1:0]       off_n, line_n, col_n;
    logic [3:0]         cand_valid;
    st_pkg::token_t     cand [4];
    st_pkg::token_t     slot [4];
    logic [1:0]         n;

    m1       = mode;
    consumed = 1'b0;
    len1     = tok_length;
    newline  = (byte_value == st_pkg::CH_NL);
    cand_valid = '0;
    cand[0] = '0;
    cand[0].kind = st_pkg::KIND_IDENT;

    case (mode)
      st_pkg::M_IDENT: begin
        if (st_pkg::is_ident_rest(byte_value)) begin
          len1 = sat_inc(tok_length);
          consumed = 1'b1;
        end else begin
          cand_valid[0] = 1'b1;
          m1 = st_pkg::M_IDLE;
        end
      end
      st_pkg::M_NUMBER: begin
        if (st_pkg::is_digit(byte_value)) begin
          len1 = sat_inc(tok_length);
          consumed = 1'b1;
        end else if (byte_value == st_pkg::CH_DOT) begin
          len1 = sat_inc(tok_length);
          m1 = st_pkg::M_FRACTION;
          consumed = 1'b1;
        end else begin
          cand_valid[0] = 1'b1;
          cand[0].kind = st_pkg::KIND_NUMBER;
          m1 = st_pkg::M_IDLE;
        end
      end
      st_pkg::M_FRACTION: begin
        if (st_pkg::is_digit(byte_value)) begin
          len1 = sat_inc(tok_length);
          consumed = 1'b1;
        end else begin
          cand_valid[0] = 1'b1;
          cand[0].kind = st_pkg::KIND_NUMBER;
          m1 = st_pkg::M_IDLE;
        end
      end
      st_pkg::M_DASH: begin
        m1 = st_pkg::M_IDLE;
        cand_valid[0] = 1'b1;
        cand[0].kind = st_pkg::KIND_SYMBOL;
        if (byte_value == st_pkg::CH_GT) begin
          len1 = P'(2);
          consumed = 1'b1;
        end
      end
      st_pkg::M_SLASH: begin
        if (byte_value == st_pkg::CH_SLASH) begin
          m1 = st_pkg::M_COMMENT;
          consumed = 1'b1;
        end else begin
          cand_valid[0] = 1'b1;
          cand[0].kind = st_pkg::KIND_SYMBOL;
          m1 = st_pkg::M_IDLE;
        end
      end
      st_pkg::M_COMMENT: begin
        if (newline) begin
          m1 = st_pkg::M_IDLE;
        end else begin
          consumed = 1'b1;
        end
      end
      default: begin
        m1 = st_pkg::M_IDLE;
      end
    endcase

    cand[0].start  = 16'(tok_start);
    cand[0].length = 16'(len1);
    cand[0].line   = 16'(tok_line);
    cand[0].column = 16'(tok_column);
    cand[0].last   = 1'b0;

    // fresh scan of the word when it did not extend the pending token
    m2              = m1;
    tok_start_next  = tok_start;
    tok_line_next   = tok_line;
    tok_column_next = tok_column;
    tok_length_next = len1;
    if (!consumed) begin
      if (st_pkg::is_space(byte_value)) begin
        m2 = m1;
      end else if (st_pkg::is_digit(byte_value)) begin
        m2 = st_pkg::M_NUMBER;
      end else if (st_pkg::is_ident_start(byte_value)) begin
        m2 = st_pkg::M_IDENT;
      end else if ((byte_value == st_pkg::CH_NUL) && final_byte) begin
        m2 = m1;
      end else if (byte_value == st_pkg::CH_DASH) begin
        m2 = st_pkg::M_DASH;
      end else if (byte_value == st_pkg::CH_SLASH) begin
        m2 = st_pkg::M_SLASH;
      end else begin
        m2 = st_pkg::M_IDLE;
        cand_valid[1] = 1'b1;
      end
      if (!st_pkg::is_space(byte_value) &&
          !((byte_value == st_pkg::CH_NUL) && final_byte)) begin
        tok_start_next  = byte_offset;
        tok_line_next   = cur_line;
        tok_column_next = cur_column;
        tok_length_next = P'(1);
      end
    end

    cand[1].kind   = st_pkg::KIND_SYMBOL;
    cand[1].start  = 16'(byte_offset);
    cand[1].length = 16'd1;
    cand[1].line   = 16'(cur_line);
    cand[1].column = 16'(cur_column);
    cand[1].last   = 1'b0;

    off_n = sat_inc(byte_offset);
    if (newline) begin
      line_n = sat_inc(cur_line);
      col_n  = '0;
    end else begin
      line_n = cur_line;
      col_n  = sat_inc(cur_column);
    end

    // flush at the final word
    cand[2].kind = st_pkg::KIND_SYMBOL;
    case (m2)
      st_pkg::M_IDENT: begin
        cand_valid[2] = final_byte;
        cand[2].kind  = st_pkg::KIND_IDENT;
      end
      st_pkg::M_NUMBER, st_pkg::M_FRACTION: begin
        cand_valid[2] = final_byte;
        cand[2].kind  = st_pkg::KIND_NUMBER;
      end
      st_pkg::M_DASH, st_pkg::M_SLASH: begin
        cand_valid[2] = final_byte;
      end
      default: begin
        cand_valid[2] = 1'b0;
      end
    endcase
    cand[2].start  = 16'(tok_start_next);
    cand[2].length = 16'(tok_length_next);
    cand[2].line   = 16'(tok_line_next);
    cand[2].column = 16'(tok_column_next);
    cand[2].last   = 1'b0;

    cand_valid[3] = final_byte;
    cand[3].kind   = st_pkg::KIND_END;
    cand[3].start  = 16'(off_n);
    cand[3].length = 16'd0;
    cand[3].line   = 16'(line_n);
    cand[3].column = 16'(col_n);
    cand[3].last   = 1'b0;

    // pack the valid tokens in order
    n = '0;
    for (int i = 0; i < 4; i++) begin
      slot[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cand_valid[i]) begin
        slot[n] = cand[i];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      slot[n - 2'd1].last = 1'b1;
    end
    group.count = n;
    for (int i = 0; i < st_pkg::MAX_RESULTS; i++) begin
      group.item[i] = slot[i];
    end

    if (final_byte) begin
      mode_next        = st_pkg::M_IDLE;
      byte_offset_next = '0;
      cur_line_next    = P'(1);
      cur_column_next  = '0;
      tok_start_next   = '0;
      tok_length_next  = '0;
      tok_line_next    = P'(1);
      tok_column_next  = '0;
    end else begin
      mode_next        = m2;
      byte_offset_next = off_n;
      cur_line_next    = line_n;
      cur_column_next  = col_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= st_pkg::M_IDLE;
      byte_offset <= '0;
      cur_line    <= P'(1);
      cur_column  <= '0;
      tok_start   <= '0;
      tok_length  <= '0;
      tok_line    <= P'(1);
      tok_column  <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      byte_offset <= byte_offset_next;
      cur_line    <= cur_line_next;
      cur_column  <= cur_column_next;
      tok_start   <= tok_start_next;
      tok_length  <= tok_length_next;
      tok_line    <= tok_line_next;
      tok_column  <= tok_column_next;
    end
  end

  a_final_emits: assert property (@(posedge clk) disable iff (rst)
    fire && final_byte |-> group.count != 2'd0)
    else $error("final word gave no end token");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    fire && final_byte |=> mode == st_pkg::M_IDLE && byte_offset == '0 && cur_line == P'(1))
    else $error("scanner not back to start after final word");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(byte_offset) && $stable(cur_line) && $stable(cur_column))
    else $error("position moved without a word");

endmodule

// ===== design/st_rqueue.sv =====
// ----------------------------------------------------------------------------
// st_rqueue
// token queue: takes up to three tokens a cycle; while pop is high and it is not empty, hands out one a cycle
// ----------------------------------------------------------------------------
module st_rqueue (
  input  logic                 clk,
  input  logic                 rst,
  input  st_pkg::token_group_t push,
  input  logic                 pop,
  output st_pkg::token_t       head,
  output logic                 not_empty,
  output logic                 has_room
);

  st_pkg::token_t                  mem [st_pkg::QUEUE_DEPTH];
  logic [st_pkg::QUEUE_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [st_pkg::QUEUE_CNT_W-1:0]  count, count_next;
  logic                            do_pop;

  assign not_empty = (count != '0);
  assign has_room  = (count <= st_pkg::QUEUE_CNT_W'(st_pkg::QUEUE_DEPTH - st_pkg::MAX_RESULTS));
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];
  assign count_next = count + st_pkg::QUEUE_CNT_W'(push.count)
                      - st_pkg::QUEUE_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < st_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push.count) begin
        mem[wr_ptr + st_pkg::QUEUE_PTR_W'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + st_pkg::QUEUE_PTR_W'(push.count);
      rd_ptr <= rd_ptr + st_pkg::QUEUE_PTR_W'(do_pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    st_pkg::QUEUE_CNT_W'(push.count) + count <= st_pkg::QUEUE_CNT_W'(st_pkg::QUEUE_DEPTH)
    + st_pkg::QUEUE_CNT_W'(do_pop))
    else $error("token queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= st_pkg::QUEUE_CNT_W'(st_pkg::QUEUE_DEPTH))
    else $error("token queue count out of range");

endmodule

// ===== design/source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer
// streaming tokenizer: one source word in, identifier, number, symbol and
// end tokens out, each with start offset, length, line and column
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready carry byte_value and final_byte, one
// source byte per word; final_byte marks the last byte of a buffer.
// output channel: out_valid/out_ready carry one token per word, with
// last_of_run set on the last token caused by a given input byte.
// a byte is scanned in the cycle it is taken; its tokens go into an
// eight-entry token queue and reach the output behind any tokens queued
// before them. throughput is one byte per cycle while the queue has room
// for three tokens; the output drains one token per cycle while out_ready
// is high, so a run of bytes that yields more than one token each is
// paced by the output side. a stalled receiver fills the queue until
// fewer than three entries are free, then in_ready drops; no token is
// lost. after the final byte the end token is queued and the position
// and scan state return to the start of a new buffer.
// reset empties the queue and sets line 1, column 0, offset 0.
// ----------------------------------------------------------------------------
module source_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  token_class,
  output logic [15:0] start_offset,
  output logic [15:0] token_length,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic        last_of_run
);

  logic                 fire;
  st_pkg::token_group_t group, push;
  st_pkg::token_t       head;

  assign fire = in_valid && in_ready;

  always_comb begin
    push = group;
    if (!fire) begin
      push.count = '0;
    end
  end

  st_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .byte_value (byte_value),
    .final_byte (final_byte),
    .group      (group)
  );

  st_rqueue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .has_room  (in_ready)
  );

  assign token_class   = head.kind;
  assign start_offset  = head.start;
  assign token_length  = head.length;
  assign line_number   = head.line;
  assign column_number = head.column;
  assign last_of_run   = head.last;

endmodule
